@@ src/wildcard_star_regex_matcher_defines.svh @@
// Assertion macros for the wildcard star regex matcher checker
`ifndef WILDCARD_STAR_REGEX_MATCHER_DEFINES_SVH
`define WILDCARD_STAR_REGEX_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define WSRM_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("wsrm check failed");

// Next-cycle implication, disabled while reset is held
`define WSRM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("wsrm check failed");

`endif

@@ src/wsrm_pkg.sv @@
// Shared types, constants and helpers for the wildcard star regex matcher
`default_nettype none
package wsrm_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int SYM_W       = 8;
  localparam int OUT_W       = 8;

  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [MAX_PATTERN-1:0][SYM_W-1:0] pat_arr_t;

  localparam sym_t SYM_DOT  = 8'd46;
  localparam sym_t SYM_STAR = 8'd42;

  typedef enum logic {
    CMD_PATTERN = 1'b0,
    CMD_TEXT    = 1'b1
  } cmd_e;

  // One request as it leaves the input register
  typedef struct packed {
    logic vld;
    cmd_e cmd;
    sym_t sym;
    logic last;
  } step_t;

  // Pattern state seen by the row update
  typedef struct packed {
    pat_arr_t pat;
    len_t     len;
    logic     ovf;
  } pat_info_t;

  function automatic logic sym_hit(input sym_t elem, input sym_t c);
    return (elem == c) || (elem == SYM_DOT);
  endfunction

endpackage
`default_nettype wire

@@ src/wildcard_star_regex_matcher.sv @@
// Top level: input register, pattern store, row update, result register
// Result path: a text byte marked last is taken into the input register; its verdict
//   is then registered into out_vld_r, out_match_r and out_ovf_r once out_free is set.
// Throughput: one request per cycle; a result held by out_tready low stalls the
//   input only once the input register also holds a request.
// Reset: rst_n low clears lengths, flags, the row and both valid flags.
`default_nettype none
module wildcard_star_regex_matcher (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire wsrm_pkg::sym_t         in_tdata,   // [7:0] symbol
  input  wire logic                   in_tuser,   // [0] command
  input  wire logic                   in_tlast,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [wsrm_pkg::OUT_W-1:0]  out_tdata   // [0] matched, [1] overflow
);
  import wsrm_pkg::*;

  logic      in_vld_r;
  cmd_e      in_cmd_r;
  sym_t      in_sym_r;
  logic      in_last_r;
  logic      adv;
  logic      out_free;
  step_t     step;
  pat_info_t info;
  logic      full_hit;
  logic      res_now;
  logic      out_vld_r, out_vld_nxt;
  logic      out_match_r, out_ovf_r;

  assign out_free  = ~out_vld_r | out_tready;
  assign adv       = in_vld_r & out_free;
  assign in_tready = ~in_vld_r | out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cmd_r  <= cmd_e'(in_tuser);
      in_sym_r  <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  assign step.vld  = adv;
  assign step.cmd  = in_cmd_r;
  assign step.sym  = in_sym_r;
  assign step.last = in_last_r;

  wsrm_pat_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .info  (info)
  );

  wsrm_row u_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .info     (info),
    .full_hit (full_hit)
  );

  assign res_now = adv && (in_cmd_r == CMD_TEXT) && in_last_r;

  always_comb begin
    priority if (res_now) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_now) begin
      out_match_r <= (info.len != '0) && ~info.ovf && full_hit;
      out_ovf_r   <= info.ovf;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_W-2){1'b0}}, out_ovf_r, out_match_r};

endmodule
`default_nettype wire

@@ src/wsrm_pat_store.sv @@
// Pattern byte store with length, open and overflow tracking
`default_nettype none
module wsrm_pat_store (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire wsrm_pkg::step_t    step,
  output wsrm_pkg::pat_info_t     info
);
  import wsrm_pkg::*;

  pat_arr_t pat_r;
  len_t     len_r, len_nxt;
  logic     open_r, open_nxt;
  logic     ovf_r, ovf_nxt;
  len_t     base;
  logic     room;
  logic     wr_en;

  always_comb begin
    // a byte that opens a new pattern starts from an empty store
    base     = open_r ? len_r : '0;
    room     = base < LEN_W'(MAX_PATTERN);
    wr_en    = 1'b0;
    len_nxt  = len_r;
    open_nxt = open_r;
    ovf_nxt  = ovf_r;
    if (step.vld) begin
      unique case (step.cmd)
        CMD_PATTERN: begin
          wr_en    = room;
          len_nxt  = room ? LEN_W'(base + 1'b1) : base;
          ovf_nxt  = (open_r & ovf_r) | ~room;
          open_nxt = ~step.last;
        end
        CMD_TEXT: begin
          open_nxt = 1'b0;
        end
        default: begin
          open_nxt = open_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      open_r <= 1'b0;
      ovf_r  <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      open_r <= open_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pat_r[base[IDX_W-1:0]] <= step.sym;
    end
  end

  assign info.pat = pat_r;
  assign info.len = len_r;
  assign info.ovf = ovf_r;

endmodule
`default_nettype wire

@@ src/wsrm_row.sv @@
// Match table row register and its parallel per-byte update
`default_nettype none
module wsrm_row (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire wsrm_pkg::step_t     step,
  input  wire wsrm_pkg::pat_info_t info,
  output logic                     full_hit
);
  import wsrm_pkg::*;

  logic [MAX_PATTERN:0] row_r, row_nxt;
  logic [MAX_PATTERN:0] start_row;
  logic [MAX_PATTERN:0] base_row;
  logic [MAX_PATTERN:0] adv_row;
  logic                 active_r, active_nxt;

  always_comb begin
    // row for the empty text prefix: only star pairs can be skipped
    start_row    = '0;
    start_row[0] = 1'b1;
    for (int j = 2; j <= MAX_PATTERN; j++) begin
      start_row[j] = (LEN_W'(j) <= info.len) && (info.pat[j-1] == SYM_STAR)
                     && start_row[j-2];
    end
  end

  assign base_row = active_r ? row_r : start_row;

  always_comb begin
    adv_row    = '0;
    adv_row[1] = (LEN_W'(1) <= info.len) && (info.pat[0] != SYM_STAR)
                 && sym_hit(info.pat[0], step.sym) && base_row[0];
    for (int j = 2; j <= MAX_PATTERN; j++) begin
      if (info.pat[j-1] == SYM_STAR) begin
        // skip the pair, or repeat the preceding element once more
        adv_row[j] = (LEN_W'(j) <= info.len)
                     && (adv_row[j-2]
                         || (sym_hit(info.pat[j-2], step.sym) && base_row[j]));
      end else begin
        adv_row[j] = (LEN_W'(j) <= info.len)
                     && sym_hit(info.pat[j-1], step.sym) && base_row[j-1];
      end
    end
  end

  assign full_hit = adv_row[info.len];

  always_comb begin
    row_nxt    = row_r;
    active_nxt = active_r;
    if (step.vld) begin
      unique case (step.cmd)
        CMD_PATTERN: active_nxt = 1'b0;
        CMD_TEXT: begin
          row_nxt    = adv_row;
          active_nxt = ~step.last;
        end
        default: active_nxt = active_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      active_r <= 1'b0;
    end else begin
      row_r    <= row_nxt;
      active_r <= active_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/wsrm_checker.sv @@
// Port-level checker for the wildcard star regex matcher, bound to the top
`default_nettype none
`include "wildcard_star_regex_matcher_defines.svh"
module wsrm_checker (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [wsrm_pkg::OUT_W-1:0] out_tdata
);
  import wsrm_pkg::*;

  logic out_stall;
  assign out_stall = out_tvalid && !out_tready;

  // a stalled result stays put
  `WSRM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_tdata))
  // only a waiting result can hold off new requests
  `WSRM_ASSERT_IMPL(a_bp_source, clk, rst_n, !in_tready, out_tvalid)
  // an overflowed pattern never reports a match
  `WSRM_ASSERT_IMPL(a_ovf_nomatch, clk, rst_n, out_tvalid, !(out_tdata[0] && out_tdata[1]))
  // padding bits stay zero
  `WSRM_ASSERT_IMPL(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[OUT_W-1:2] == '0)

endmodule

bind wildcard_star_regex_matcher wsrm_checker u_wsrm_checker (.*);
`default_nettype wire

@@ tb/tb_wildcard_star_regex_matcher.sv @@
// Testbench for the wildcard star regex matcher: random and directed patterns and texts checked against a local predictor
`timescale 1ns / 1ps
module tb_wildcard_star_regex_matcher;
  import wsrm_pkg::*;

  localparam int ITEMS_TOTAL  = 1650;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  // Predicts the match verdict of every text and checks the block's results in order
  class match_scoreboard;
    sym_t                 pat[MAX_PATTERN];
    int                   plen;
    bit                   pat_open;
    bit                   in_text;
    bit                   ovf;
    logic [MAX_PATTERN:0] row;
    verdict_t             verdict_q[$];
    int                   errors;
    int                   checked;
    int                   n_matched;
    int                   n_overflow;

    function new();
      plen = 0;
      pat_open = 0;
      in_text = 0;
      ovf = 0;
      row = '0;
      errors = 0;
      checked = 0;
      n_matched = 0;
      n_overflow = 0;
      foreach (pat[i]) pat[i] = '0;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    task report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    // Row for the empty text prefix: only star pairs can match nothing
    function void start_row();
      row = '0;
      row[0] = 1'b1;
      for (int j = 2; j <= plen; j++) begin
        if (pat[j-1] == SYM_STAR && row[j-2]) row[j] = 1'b1;
      end
    endfunction

    function void advance_row(input sym_t c);
      logic [MAX_PATTERN:0] nxt;
      sym_t                 e;
      nxt = '0;
      for (int j = 1; j <= plen; j++) begin
        if (pat[j-1] == SYM_STAR) begin
          // leading star stays false
          if (j >= 2) begin
            e = pat[j-2];
            nxt[j] = nxt[j-2] || (((e == c) || (e == SYM_DOT)) && row[j]);
          end
        end else begin
          e = pat[j-1];
          nxt[j] = ((e == c) || (e == SYM_DOT)) && row[j-1];
        end
      end
      row = nxt;
    endfunction

    function void take_request(input cmd_e cmd, input sym_t sym, input logic last);
      verdict_t v;
      if (cmd == CMD_PATTERN) begin
        in_text = 0;
        if (!pat_open) begin
          plen = 0;
          ovf = 0;
          pat_open = 1;
        end
        if (plen < MAX_PATTERN) begin
          pat[plen] = sym;
          plen++;
        end else begin
          ovf = 1;
        end
        if (last) pat_open = 0;
      end else begin
        pat_open = 0;
        if (!in_text) begin
          start_row();
          in_text = 1;
        end
        advance_row(sym);
        if (last) begin
          in_text = 0;
          v.matched  = (plen > 0) && !ovf && row[plen];
          v.overflow = ovf;
          verdict_q.push_back(v);
        end
      end
    endfunction

    task check_verdict(input logic [OUT_W-1:0] data);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("result %h with no text pending", data));
        return;
      end
      want = verdict_q.pop_front();
      checked++;
      if (want.matched) n_matched++;
      if (want.overflow) n_overflow++;
      if (data[0] !== want.matched)
        report_mismatch($sformatf("matched %b, want %b", data[0], want.matched));
      if (data[1] !== want.overflow)
        report_mismatch($sformatf("overflow %b, want %b", data[1], want.overflow));
      if (data[OUT_W-1:2] !== '0)
        report_mismatch($sformatf("padding bits %h not zero", data[OUT_W-1:2]));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  sym_t              in_tdata = '0;   // [7:0] symbol
  logic              in_tuser = 1'b0; // [0] command
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;       // [0] matched, [1] overflow

  match_scoreboard sb = new();

  int   cycles = 0;
  int   n_items = 0;
  int   n_texts = 0;
  int   n_holds = 0;
  bit   idle_in = 1'b1;
  bit   idle_out = 1'b1;
  bit   hold_req = 1'b0;
  sym_t pat_q[$];
  sym_t txt_q[$];

  wildcard_star_regex_matcher i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d texts still pending", cycles, sb.pending());
      $display("tb_wildcard_star_regex_matcher: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_verdict(out_tdata);
  end

  // Call right after a rising edge; returns at the edge that accepts the request
  task automatic send_request(input cmd_e cmd, input sym_t sym, input logic last);
    int gap;
    gap = idle_in ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    in_tuser  <= cmd;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_request(cmd, sym, last);
    n_items++;
    if (cmd == CMD_TEXT && last) n_texts++;
  endtask

  task automatic send_pattern(input bit keep_open);
    foreach (pat_q[i])
      send_request(CMD_PATTERN, pat_q[i], !keep_open && (i == pat_q.size() - 1));
  endtask

  task automatic send_text(input bit abandon);
    foreach (txt_q[i])
      send_request(CMD_TEXT, txt_q[i], !abandon && (i == txt_q.size() - 1));
  endtask

  function automatic sym_t pick_letter();
    case ($urandom_range(0, 4))
      0, 1:    return "a";
      2, 3:    return "b";
      default: return sym_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void build_pattern(input int len);
    pat_q.delete();
    for (int i = 0; i < len; i++) begin
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 5 && i > 0 && pat_q[i-1] != SYM_STAR) pat_q.push_back(SYM_STAR);
      else if (pick == 5) pat_q.push_back(SYM_STAR);
      else if (pick < 10) pat_q.push_back("a");
      else if (pick < 14) pat_q.push_back("b");
      else if (pick < 18) pat_q.push_back(SYM_DOT);
      else pat_q.push_back(sym_t'($urandom_range(0, 255)));
    end
  endfunction

  // Expand the pattern into a text that usually matches, or draw a loose one
  function automatic void build_text(input bit derived);
    int   reps;
    sym_t e;
    txt_q.delete();
    if (derived) begin
      foreach (pat_q[i]) begin
        e = pat_q[i];
        if (e == SYM_STAR) continue;
        reps = (i + 1 < pat_q.size() && pat_q[i+1] == SYM_STAR) ? $urandom_range(0, 3) : 1;
        repeat (reps) txt_q.push_back(e == SYM_DOT ? sym_t'($urandom_range(0, 255)) : e);
      end
      if (txt_q.size() > 0 && $urandom_range(0, 7) == 0)
        txt_q[$urandom_range(0, txt_q.size() - 1)] = pick_letter();
    end else begin
      repeat ($urandom_range(1, 8)) txt_q.push_back(pick_letter());
    end
    if (txt_q.size() == 0) txt_q.push_back("a");
  endfunction

  function automatic int draw_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 6);
    if (r < 17) return $urandom_range(7, MAX_PATTERN);
    if (r < 18) return MAX_PATTERN;
    return $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 8);
  endfunction

  // Result side: random stalls per result, one long hold-off on request
  initial begin
    int stall;
    int seen;
    seen = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        n_holds++;
      end
      if (seen % 64 == 0) idle_out = ($urandom_range(0, 3) != 0);
      stall = idle_out ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      seen++;
    end
  end

  initial begin
    int  ntexts;
    bit  keep_open;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // text before any pattern: empty pattern never matches
    send_request(CMD_TEXT, "x", 1'b1);
    // leading star
    send_request(CMD_PATTERN, SYM_STAR, 1'b0);
    send_request(CMD_PATTERN, "a", 1'b1);
    send_request(CMD_TEXT, "a", 1'b1);
    // dot star over the byte extremes
    send_request(CMD_PATTERN, SYM_DOT, 1'b0);
    send_request(CMD_PATTERN, SYM_STAR, 1'b1);
    send_request(CMD_TEXT, 8'hFF, 1'b0);
    send_request(CMD_TEXT, 8'h00, 1'b1);
    // star after star compares the first star literally
    send_request(CMD_PATTERN, "a", 1'b0);
    send_request(CMD_PATTERN, SYM_STAR, 1'b0);
    send_request(CMD_PATTERN, SYM_STAR, 1'b1);
    send_request(CMD_TEXT, "a", 1'b0);
    send_request(CMD_TEXT, SYM_STAR, 1'b1);
    // abandon a text with a pattern byte, then close the open pattern with text
    send_request(CMD_TEXT, "a", 1'b0);
    send_request(CMD_PATTERN, "b", 1'b0);
    send_request(CMD_TEXT, "b", 1'b1);
    // literal extremes
    send_request(CMD_PATTERN, 8'h00, 1'b0);
    send_request(CMD_PATTERN, 8'hFF, 1'b1);
    send_request(CMD_TEXT, 8'h00, 1'b0);
    send_request(CMD_TEXT, 8'hFF, 1'b1);

    // hold the result side while short texts keep coming
    idle_in = 1'b0;
    hold_req = 1'b1;
    send_request(CMD_PATTERN, "a", 1'b1);
    repeat (40) send_request(CMD_TEXT, "a", 1'b1);

    // pattern two past the store, then texts under overflow
    build_pattern(MAX_PATTERN + 2);
    send_pattern(1'b0);
    repeat (2) begin
      build_text(1'b1);
      send_text(1'b0);
    end

    while (n_items < ITEMS_TOTAL) begin
      idle_in = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 19) == 0) begin
        // noise: anything goes
        repeat ($urandom_range(3, 6))
          send_request(cmd_e'($urandom_range(0, 1)), sym_t'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
        continue;
      end
      build_pattern(draw_length());
      keep_open = ($urandom_range(0, 9) == 0);
      send_pattern(keep_open);
      ntexts = $urandom_range(1, 4);
      for (int t = 0; t < ntexts; t++) begin
        build_text($urandom_range(0, 2) != 0);
        send_text(t == ntexts - 1 && $urandom_range(0, 9) == 0);
      end
    end
    in_tvalid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d requests, %0d texts checked (%0d matched, %0d overflowed)",
             n_items, sb.checked, sb.n_matched, sb.n_overflow);
    $display("long result hold-offs: %0d, mismatches: %0d", n_holds, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_wildcard_star_regex_matcher: PASS");
    end else begin
      $display("tb_wildcard_star_regex_matcher: FAIL");
    end
    $finish;
  end

endmodule
